### rtl/sctl_pkg.sv
// shared types and constants for the set associative cache tag lookup
// no dependencies

package sctl_pkg;

    localparam int ADDR_BITS    = 48;
    localparam int NUM_SETS_DEF = 1024;
    localparam int NUM_WAYS_DEF = 16;
    localparam int CFG_ADDR_W   = 4;
    localparam int IDX_W        = 15;

    localparam logic [15:0] LFSR_SEED = 16'hACE1;
    localparam logic [15:0] LFSR_TAPS = 16'hB400;

    localparam logic [1:0] REG_OFFSET = 2'd0;
    localparam logic [1:0] REG_INDEX  = 2'd1;
    localparam logic [1:0] REG_POLICY = 2'd2;

    localparam logic POLICY_LRU    = 1'b0;
    localparam logic POLICY_RANDOM = 1'b1;

    localparam logic [3:0] OFFSET_RST = 4'd6;
    localparam logic [3:0] INDEX_RST  = 4'd7;

    typedef struct packed {
        logic [ADDR_BITS-1:0] address;
        logic                 is_write;
    } req_t;

    typedef struct packed {
        logic        hit;
        logic [3:0]  way;
        logic        evicted;
        logic [31:0] miss_total;
        logic [31:0] read_miss_total;
        logic [31:0] write_miss_total;
    } rsp_t;

    typedef struct packed {
        logic [3:0] offset_bits;
        logic [3:0] index_bits;
        logic       policy;
    } cfg_t;

    typedef struct packed {
        logic clear;
        logic capture;
        logic split;
        logic index;
        logic update;
    } cmd_t;

    typedef struct packed {
        logic clear_last;
    } stat_t;

    function automatic logic [15:0] lfsr_step(input logic [15:0] v);
        logic [15:0] n;
        n = v >> 1;
        if (v[0])
        begin
            n = n ^ LFSR_TAPS;
        end
        return n;
    endfunction

endpackage

### rtl/sctl_ctrl.sv
// controller state machine for the tag lookup
// depends on sctl_pkg

module sctl_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  logic           out_ready,
    input  sctl_pkg::stat_t stat,
    output sctl_pkg::cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SPLIT,
        S_READ,
        S_UPDATE
    } state_t;

    state_t state_reg;
    logic   out_valid_reg;
    logic   slot_free;

    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        cmd         = '0;
        cmd.clear   = (state_reg == S_CLEAR);
        cmd.capture = (state_reg == S_IDLE) && in_valid;
        cmd.split   = (state_reg == S_SPLIT);
        cmd.index   = (state_reg == S_READ);
        cmd.update  = (state_reg == S_UPDATE) && slot_free;
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if ((state_reg == S_UPDATE) && slot_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLEAR:
                begin
                    if (stat.clear_last)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= S_SPLIT;
                    end
                end
                S_SPLIT:
                begin
                    state_reg <= S_READ;
                end
                S_READ:
                begin
                    state_reg <= S_UPDATE;
                end
                S_UPDATE:
                begin
                    if (slot_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_CLEAR;
                end
            endcase
        end
    end

endmodule

### rtl/sctl_dp.sv
// datapath: address split, set memory, tag compare, replacement and counters
// depends on sctl_pkg

module sctl_dp #(
    parameter int NUM_SETS = sctl_pkg::NUM_SETS_DEF,
    parameter int NUM_WAYS = sctl_pkg::NUM_WAYS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  sctl_pkg::cmd_t  cmd,
    output sctl_pkg::stat_t stat,
    input  sctl_pkg::cfg_t  cfg,
    input  sctl_pkg::req_t  req,
    output sctl_pkg::rsp_t  rsp
);

    localparam int TAG_W = sctl_pkg::ADDR_BITS;
    localparam int SET_W = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int WAY_W = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
    localparam int IDX_W = sctl_pkg::IDX_W;
    localparam logic [32:0] SET_M = 33'(((64'd1 << 32) + NUM_SETS - 1) / NUM_SETS);
    localparam logic [32:0] WAY_M = 33'(((64'd1 << 32) + NUM_WAYS - 1) / NUM_WAYS);

    typedef logic [NUM_WAYS-1:0][TAG_W-1:0] tag_row_t;
    typedef logic [NUM_WAYS-1:0][WAY_W-1:0] rank_row_t;
    typedef logic [NUM_WAYS-1:0]            vld_row_t;

    tag_row_t  mem_tag  [NUM_SETS];
    rank_row_t mem_rank [NUM_SETS];
    vld_row_t  mem_vld  [NUM_SETS];

    sctl_pkg::req_t req_reg;
    logic [TAG_W-1:0] tag_reg;
    logic [IDX_W-1:0] v_reg;
    logic [IDX_W-1:0] sq_reg;
    logic [15:0]      lnext_reg;
    logic [15:0]      lq_reg;
    logic [SET_W-1:0] set_reg;
    logic [WAY_W-1:0] pick_reg;
    logic [SET_W-1:0] clr_cnt_reg;
    logic [15:0]      lfsr_reg;
    logic [31:0]      all_reg, rd_miss_reg, wr_miss_reg;
    tag_row_t         rd_tag_reg;
    rank_row_t        rd_rank_reg;
    vld_row_t         rd_vld_reg;
    sctl_pkg::rsp_t   rsp_reg;

    logic [TAG_W-1:0] blk;
    logic [IDX_W-1:0] imask;
    logic [IDX_W-1:0] v_next;
    logic [47:0]      sprod;
    logic [48:0]      lprod;
    logic [15:0]      lnext;
    logic [31:0]      set_rem;
    logic [31:0]      way_rem;
    logic [SET_W-1:0] set_idx;

    assign stat.clear_last = (clr_cnt_reg == SET_W'(NUM_SETS - 1));
    assign rsp = rsp_reg;

    // address split and reciprocal quotients
    always_comb
    begin
        blk     = req_reg.address >> cfg.offset_bits;
        imask   = (IDX_W'(1) << cfg.index_bits) - IDX_W'(1);
        v_next  = IDX_W'(blk) & imask;
        sprod   = 48'(v_next) * 48'(SET_M);
        lnext   = sctl_pkg::lfsr_step(lfsr_reg);
        lprod   = 49'(lnext) * 49'(WAY_M);
        set_rem = 32'(v_reg) - 32'(sq_reg) * 32'(NUM_SETS);
        way_rem = 32'(lnext_reg) - 32'(lq_reg) * 32'(NUM_WAYS);
        set_idx = set_rem[SET_W-1:0];
    end

    // lookup and replacement
    logic [NUM_WAYS-1:0] match;
    logic                hit, free_any;
    logic [WAY_W-1:0]    hit_way, free_way, rz_way, victim, old_rank;
    logic                lru, miss, evict;
    rank_row_t           new_rank;
    tag_row_t            new_tag;
    vld_row_t            new_vld;

    always_comb
    begin
        lru      = (cfg.policy == sctl_pkg::POLICY_LRU);
        hit_way  = '0;
        free_way = '0;
        rz_way   = '0;
        free_any = 1'b0;
        for (int w = NUM_WAYS - 1; w >= 0; w--)
        begin
            match[w] = rd_vld_reg[w] && (rd_tag_reg[w] == tag_reg);
            if (match[w])
            begin
                hit_way = WAY_W'(w);
            end
            if (!rd_vld_reg[w])
            begin
                free_way = WAY_W'(w);
                free_any = 1'b1;
            end
            if (rd_rank_reg[w] == '0)
            begin
                rz_way = WAY_W'(w);
            end
        end
        hit   = |match;
        miss  = !hit;
        evict = miss && !free_any;
        if (hit)
        begin
            victim = hit_way;
        end
        else if (free_any)
        begin
            victim = free_way;
        end
        else if (lru)
        begin
            victim = rz_way;
        end
        else
        begin
            victim = pick_reg;
        end
        old_rank = rd_rank_reg[victim];
        new_tag  = rd_tag_reg;
        new_vld  = rd_vld_reg;
        new_rank = rd_rank_reg;
        if (miss)
        begin
            new_tag[victim] = tag_reg;
            new_vld[victim] = 1'b1;
        end
        if (lru)
        begin
            for (int i = 0; i < NUM_WAYS; i++)
            begin
                if (WAY_W'(i) == victim)
                begin
                    new_rank[i] = WAY_W'(NUM_WAYS - 1);
                end
                else if (rd_rank_reg[i] > old_rank)
                begin
                    new_rank[i] = rd_rank_reg[i] - WAY_W'(1);
                end
            end
        end
    end

    // row write port
    logic             wr_en;
    logic [SET_W-1:0] wr_addr;
    tag_row_t         wr_tag;
    rank_row_t        wr_rank;
    vld_row_t         wr_vld;

    always_comb
    begin
        wr_en   = cmd.clear || cmd.update;
        wr_addr = cmd.clear ? clr_cnt_reg : set_reg;
        wr_tag  = new_tag;
        wr_vld  = cmd.clear ? '0 : new_vld;
        wr_rank = new_rank;
        if (cmd.clear)
        begin
            for (int w = 0; w < NUM_WAYS; w++)
            begin
                wr_rank[w] = WAY_W'(w);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_tag[wr_addr]  <= wr_tag;
            mem_rank[wr_addr] <= wr_rank;
            mem_vld[wr_addr]  <= wr_vld;
        end
        if (cmd.index)
        begin
            rd_tag_reg  <= mem_tag[set_idx];
            rd_rank_reg <= mem_rank[set_idx];
            rd_vld_reg  <= mem_vld[set_idx];
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg <= req;
        end
        if (cmd.split)
        begin
            tag_reg   <= req_reg.address >> (5'(cfg.offset_bits) + 5'(cfg.index_bits));
            v_reg     <= v_next;
            sq_reg    <= sprod[32 +: IDX_W];
            lnext_reg <= lnext;
            lq_reg    <= lprod[47:32];
        end
        if (cmd.index)
        begin
            set_reg  <= set_idx;
            pick_reg <= way_rem[WAY_W-1:0];
        end
        if (cmd.update)
        begin
            rsp_reg.hit              <= hit;
            rsp_reg.way              <= 4'(victim);
            rsp_reg.evicted          <= evict;
            rsp_reg.miss_total       <= (miss && all_reg != '1) ? all_reg + 32'd1 : all_reg;
            rsp_reg.read_miss_total  <= (miss && !req_reg.is_write && rd_miss_reg != '1)
                                        ? rd_miss_reg + 32'd1 : rd_miss_reg;
            rsp_reg.write_miss_total <= (miss && req_reg.is_write && wr_miss_reg != '1)
                                        ? wr_miss_reg + 32'd1 : wr_miss_reg;
        end
    end

    // control state: sweep counter, lfsr, miss counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
            lfsr_reg    <= sctl_pkg::LFSR_SEED;
            all_reg     <= '0;
            rd_miss_reg <= '0;
            wr_miss_reg <= '0;
        end
        else
        begin
            if (cmd.clear && !stat.clear_last)
            begin
                clr_cnt_reg <= clr_cnt_reg + SET_W'(1);
            end
            if (cmd.update && miss)
            begin
                if (evict && !lru)
                begin
                    lfsr_reg <= lnext_reg;
                end
                if (all_reg != '1)
                begin
                    all_reg <= all_reg + 32'd1;
                end
                if (req_reg.is_write && wr_miss_reg != '1)
                begin
                    wr_miss_reg <= wr_miss_reg + 32'd1;
                end
                if (!req_reg.is_write && rd_miss_reg != '1)
                begin
                    rd_miss_reg <= rd_miss_reg + 32'd1;
                end
            end
        end
    end

endmodule

### rtl/set_assoc_cache_tag_lookup.sv
// Set associative cache tag lookup with LRU or random replacement. After reset the
// block sweeps its set memory once, one set per cycle, before it takes the first
// request; register writes are taken throughout. Each request then reaches its result
// register through these steps in order: address split with reciprocal set quotient,
// set row read from the tag/rank memory, and the compare/replace/write-back step. No
// new request is taken until that last step is done, and the write-back step waits
// while an earlier result is held.
// depends on sctl_pkg, sctl_ctrl, sctl_dp

module set_assoc_cache_tag_lookup #(
    parameter int NUM_SETS = sctl_pkg::NUM_SETS_DEF,
    parameter int NUM_WAYS = sctl_pkg::NUM_WAYS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  sctl_pkg::req_t                in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output sctl_pkg::rsp_t                out_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sctl_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    sctl_pkg::cfg_t  cfg_reg;
    sctl_pkg::cmd_t  cmd;
    sctl_pkg::stat_t stat;
    logic [1:0]      reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.offset_bits <= sctl_pkg::OFFSET_RST;
            cfg_reg.index_bits  <= sctl_pkg::INDEX_RST;
            cfg_reg.policy      <= sctl_pkg::POLICY_LRU;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (reg_sel)
                sctl_pkg::REG_OFFSET: cfg_reg.offset_bits <= pwdata[3:0];
                sctl_pkg::REG_INDEX:  cfg_reg.index_bits  <= pwdata[3:0];
                sctl_pkg::REG_POLICY: cfg_reg.policy      <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            sctl_pkg::REG_OFFSET: prdata = {28'd0, cfg_reg.offset_bits};
            sctl_pkg::REG_INDEX:  prdata = {28'd0, cfg_reg.index_bits};
            sctl_pkg::REG_POLICY: prdata = {31'd0, cfg_reg.policy};
            default:              prdata = '0;
        endcase
    end

    sctl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    sctl_dp #(
        .NUM_SETS (NUM_SETS),
        .NUM_WAYS (NUM_WAYS)
    ) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .stat  (stat),
        .cfg   (cfg_reg),
        .req   (in_data),
        .rsp   (out_data)
    );

    // busy after a request is taken
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("request taken while busy");

    a_evict_miss: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.evicted) |-> !out_data.hit)
        else $error("eviction reported on a hit");

    a_miss_sum: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.miss_total != '1) |->
        (33'(out_data.miss_total) ==
         33'(out_data.read_miss_total) + 33'(out_data.write_miss_total)))
        else $error("miss counters disagree");

    a_way_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (7'(out_data.way) < 7'(NUM_WAYS) || NUM_WAYS > 16))
        else $error("way out of range");

endmodule

### test/set_assoc_cache_tag_lookup_tb.sv
// testbench for set_assoc_cache_tag_lookup: directed and random accesses checked
// against an in-bench model of the tag store, recency ranks, lfsr and miss counters
// depends on sctl_pkg and the set_assoc_cache_tag_lookup rtl

module set_assoc_cache_tag_lookup_tb;

    localparam int SETS = sctl_pkg::NUM_SETS_DEF;
    localparam int WAYS = sctl_pkg::NUM_WAYS_DEF;
    localparam int ABITS = sctl_pkg::ADDR_BITS;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    sctl_pkg::req_t in_data;
    logic        out_valid;
    logic        out_ready;
    sctl_pkg::rsp_t out_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [sctl_pkg::CFG_ADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    set_assoc_cache_tag_lookup u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    // model state
    logic [ABITS-1:0]     line_tag [SETS][WAYS];
    logic                 line_vld [SETS][WAYS];
    logic [3:0]           line_rank[SETS][WAYS];
    logic [15:0]          victim_lfsr;
    logic [31:0]          misses_all;
    logic [31:0]          misses_rd;
    logic [31:0]          misses_wr;
    logic [3:0]           cfg_offset;
    logic [3:0]           cfg_index;
    logic                 cfg_policy;

    sctl_pkg::rsp_t pending_rsp[$];
    int   send_idle_pct;
    int   recv_idle_pct;
    bit   failed;
    int   hot_addr_base;

    always #4 clk = ~clk;

    task automatic promote_way(input int s, input int w);
        logic [3:0] old;
        old = line_rank[s][w];
        for (int i = 0; i < WAYS; i++)
        begin
            if (i != w && line_rank[s][i] > old)
            begin
                line_rank[s][i] = line_rank[s][i] - 4'd1;
            end
        end
        line_rank[s][w] = 4'(WAYS - 1);
    endtask

    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

    task automatic predict_lookup(input sctl_pkg::req_t r);
        logic [63:0] addr;
        logic [63:0] blk;
        logic [63:0] tag;
        int          s;
        int          w;
        int          free_w;
        logic        hit;
        logic        evicted;
        sctl_pkg::rsp_t e;
        addr = 64'(r.address);
        blk = addr >> cfg_offset;
        s = int'((blk & ((64'd1 << cfg_index) - 64'd1)) % SETS);
        tag = addr >> (32'(cfg_offset) + 32'(cfg_index));
        hit = 1'b0;
        evicted = 1'b0;
        w = 0;
        free_w = -1;
        for (int i = 0; i < WAYS; i++)
        begin
            if (line_vld[s][i])
            begin
                if (!hit && 64'(line_tag[s][i]) == tag)
                begin
                    hit = 1'b1;
                    w = i;
                end
            end
            else if (free_w < 0)
            begin
                free_w = i;
            end
        end
        if (hit)
        begin
            if (cfg_policy == sctl_pkg::POLICY_LRU)
            begin
                promote_way(s, w);
            end
        end
        else
        begin
            misses_all = sat_inc(misses_all);
            if (r.is_write)
            begin
                misses_wr = sat_inc(misses_wr);
            end
            else
            begin
                misses_rd = sat_inc(misses_rd);
            end
            if (free_w >= 0)
            begin
                w = free_w;
            end
            else
            begin
                evicted = 1'b1;
                if (cfg_policy == sctl_pkg::POLICY_LRU)
                begin
                    w = 0;
                    for (int i = WAYS - 1; i >= 0; i--)
                    begin
                        if (line_rank[s][i] == 4'd0)
                        begin
                            w = i;
                        end
                    end
                end
                else
                begin
                    victim_lfsr = (victim_lfsr >> 1)
                                  ^ (victim_lfsr[0] ? sctl_pkg::LFSR_TAPS : 16'h0);
                    w = int'(victim_lfsr % WAYS);
                end
            end
            line_vld[s][w] = 1'b1;
            line_tag[s][w] = tag[ABITS-1:0];
            if (cfg_policy == sctl_pkg::POLICY_LRU)
            begin
                promote_way(s, w);
            end
        end
        e.hit = hit;
        e.way = 4'(w);
        e.evicted = evicted;
        e.miss_total = misses_all;
        e.read_miss_total = misses_rd;
        e.write_miss_total = misses_wr;
        pending_rsp.push_back(e);
    endtask

    task automatic send_request(input logic [ABITS-1:0] a, input logic wr);
        sctl_pkg::req_t r;
        r.address = a;
        r.is_write = wr;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= r;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        predict_lookup(r);
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        sctl_pkg::rsp_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_rsp.size() == 0)
            begin
                $error("response with no request outstanding");
                failed = 1'b1;
            end
            else
            begin
                e = pending_rsp.pop_front();
                if (out_data.hit !== e.hit)
                begin
                    $error("hit exp %0d got %0d", e.hit, out_data.hit);
                    failed = 1'b1;
                end
                if (out_data.way !== e.way)
                begin
                    $error("way exp %0d got %0d", e.way, out_data.way);
                    failed = 1'b1;
                end
                if (out_data.evicted !== e.evicted)
                begin
                    $error("evicted exp %0d got %0d", e.evicted, out_data.evicted);
                    failed = 1'b1;
                end
                if (out_data.miss_total !== e.miss_total)
                begin
                    $error("miss_total exp %0d got %0d", e.miss_total, out_data.miss_total);
                    failed = 1'b1;
                end
                if (out_data.read_miss_total !== e.read_miss_total)
                begin
                    $error("read_miss_total exp %0d got %0d", e.read_miss_total,
                           out_data.read_miss_total);
                    failed = 1'b1;
                end
                if (out_data.write_miss_total !== e.write_miss_total)
                begin
                    $error("write_miss_total exp %0d got %0d", e.write_miss_total,
                           out_data.write_miss_total);
                    failed = 1'b1;
                end
            end
        end
    end

    task automatic drain;
        in_valid <= 1'b0;
        while (pending_rsp.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= sctl_pkg::CFG_ADDR_W'({idx, 2'b00});
        pwdata <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        case (idx)
            sctl_pkg::REG_OFFSET: cfg_offset = v[3:0];
            sctl_pkg::REG_INDEX:  cfg_index = v[3:0];
            default:              cfg_policy = v[0];
        endcase
    endtask

    task automatic set_config(input logic [3:0] o, input logic [3:0] i, input logic p);
        drain();
        write_reg(sctl_pkg::REG_OFFSET, 32'(o));
        write_reg(sctl_pkg::REG_INDEX, 32'(i));
        write_reg(sctl_pkg::REG_POLICY, 32'(p));
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    function automatic logic [ABITS-1:0] rand_addr;
        return ABITS'({$urandom, $urandom});
    endfunction

    // few tags per set so hits, fills and evictions all occur
    function automatic logic [ABITS-1:0] hot_addr;
        logic [63:0] tag;
        logic [63:0] s;
        tag = 64'($urandom_range(20)) + 64'(hot_addr_base);
        s = 64'($urandom_range(3));
        return ABITS'((((tag << cfg_index) | s) << cfg_offset) | 64'($urandom_range(63)));
    endfunction

    task automatic test_directed;
        send_request('0, 1'b0);
        send_request('0, 1'b1);
        send_request('1, 1'b1);
        send_request('1, 1'b0);
        send_request(48'h5555_5555_5555, 1'b0);
        send_request(48'hAAAA_AAAA_AAAA, 1'b1);
        // fill one set past its ways to force an lru eviction
        for (int t = 1; t <= WAYS + 2; t++)
        begin
            send_request(ABITS'(t) << 13, t[0]);
        end
    endtask

    task automatic test_config_extremes;
        set_config(4'd0, 4'd0, sctl_pkg::POLICY_LRU);
        repeat (20) send_request(ABITS'($urandom_range(40)), 1'($urandom_range(1)));
        set_config(4'd15, 4'd15, sctl_pkg::POLICY_RANDOM);
        repeat (20) send_request(rand_addr(), 1'($urandom_range(1)));
        set_config(4'd12, 4'd10, sctl_pkg::POLICY_RANDOM);
        repeat (20) send_request(hot_addr(), 1'($urandom_range(1)));
    endtask

    task automatic test_random(input int n);
        logic [3:0] o;
        logic [3:0] i;
        for (int ph = 0; ph < 6; ph++)
        begin
            o = 4'($urandom_range(12));
            i = 4'($urandom_range(10));
            set_config(o, i, ph[0]);
            hot_addr_base = $urandom_range(1000);
            for (int k = 0; k < n; k++)
            begin
                if ($urandom_range(9) < 8)
                begin
                    send_request(hot_addr(), 1'($urandom_range(1)));
                end
                else
                begin
                    send_request(rand_addr(), 1'($urandom_range(1)));
                end
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        hot_addr_base = 0;
        send_idle_pct = 8;
        recv_idle_pct = 61;
        for (int s = 0; s < SETS; s++)
        begin
            for (int w = 0; w < WAYS; w++)
            begin
                line_vld[s][w] = 1'b0;
                line_tag[s][w] = '0;
                line_rank[s][w] = 4'(w);
            end
        end
        victim_lfsr = sctl_pkg::LFSR_SEED;
        misses_all = '0;
        misses_rd = '0;
        misses_wr = '0;
        cfg_offset = sctl_pkg::OFFSET_RST;
        cfg_index = sctl_pkg::INDEX_RST;
        cfg_policy = sctl_pkg::POLICY_LRU;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_config_extremes();
        test_random(60);
        send_idle_pct = 61;
        recv_idle_pct = 8;
        test_random(60);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(60);
        drain();
        if (!failed)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial
    begin
        #4000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

### set_assoc_cache_tag_lookup.f
rtl/sctl_pkg.sv
rtl/sctl_ctrl.sv
rtl/sctl_dp.sv
rtl/set_assoc_cache_tag_lookup.sv
test/set_assoc_cache_tag_lookup_tb.sv
